// ----- design/mer_pkg.sv -----
// Shared types and codes for the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

	// Operation codes carried on the input tuser.
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Controller states, one-hot.
	typedef enum logic [14:0] {
		ST_IDLE    = 15'b000000000000001,
		ST_MUL_RX  = 15'b000000000000010,
		ST_MUL_RY  = 15'b000000000000100,
		ST_MUL_GY  = 15'b000000000001000,
		ST_INIT    = 15'b000000000010000,
		ST_ADV_POS = 15'b000000000100000,
		ST_ADV_DEC = 15'b000000001000000,
		ST_CHECK   = 15'b000000010000000,
		ST_R2_TX   = 15'b000000100000000,
		ST_R2_A    = 15'b000001000000000,
		ST_R2_TY   = 15'b000010000000000,
		ST_R2_B    = 15'b000100000000000,
		ST_R2_C    = 15'b001000000000000,
		ST_R2_D    = 15'b010000000000000,
		ST_EMIT    = 15'b100000000000000
	} mer_state_t;

	// Operand pairs for the shared multiplier.
	typedef enum logic [2:0] {
		MUL_RX_RX,
		MUL_RY_RY,
		MUL_RXSQ_RY,
		MUL_TX_TX,
		MUL_RYSQ_PROD,
		MUL_TY_TY,
		MUL_RXSQ_PROD,
		MUL_RXSQ_RYSQ
	} mul_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     save_rxsq;
		logic     save_rysq;
		logic     init;
		logic     adv_pos;
		logic     adv_dec;
		logic     acc_load;
		logic     acc_add;
		logic     r2_finish;
		logic     emit;
	} mer_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;
		logic region_two;
		logic grad_lt;
		logic out_free;
	} mer_stat_t;

endpackage

// ----- design/mer_ctrl.sv -----
// Controller state machine of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

module mer_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tuser,
	output logic              s_tready,
	input  mer_pkg::mer_stat_t stat,
	output mer_pkg::mer_cmd_t  cmd
);
	import mer_pkg::*;

	mer_state_t state_q;
	mer_state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = MUL_RX_RX;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == OP_START) begin
						cmd.load = 1'b1;
						state_d  = ST_MUL_RX;
					end else if (stat.busy) begin
						state_d = ST_ADV_POS;
					end
				end
			end
			ST_MUL_RX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RX_RX;
				state_d     = ST_MUL_RY;
			end
			ST_MUL_RY: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_RY_RY;
				cmd.save_rxsq = 1'b1;
				state_d       = ST_MUL_GY;
			end
			ST_MUL_GY: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_RXSQ_RY;
				cmd.save_rysq = 1'b1;
				state_d       = ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_ADV_POS: begin
				cmd.adv_pos = 1'b1;
				state_d     = ST_ADV_DEC;
			end
			ST_ADV_DEC: begin
				cmd.adv_dec = 1'b1;
				state_d     = ST_CHECK;
			end
			ST_CHECK: begin
				if (!stat.region_two && !stat.grad_lt) begin
					state_d = ST_R2_TX;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_R2_TX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_TX_TX;
				state_d     = ST_R2_A;
			end
			ST_R2_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RYSQ_PROD;
				state_d     = ST_R2_TY;
			end
			ST_R2_TY: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_TY_TY;
				cmd.acc_load = 1'b1;
				state_d      = ST_R2_B;
			end
			ST_R2_B: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RXSQ_PROD;
				state_d     = ST_R2_C;
			end
			ST_R2_C: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RXSQ_RYSQ;
				cmd.acc_add = 1'b1;
				state_d     = ST_R2_D;
			end
			ST_R2_D: begin
				cmd.r2_finish = 1'b1;
				state_d       = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/mer_dp.sv -----
// Datapath of the midpoint ellipse rasterizer: point state, shared multiplier, result register.
`timescale 1ns / 1ps

module mer_dp #(
	parameter int COORD_WIDTH  = 11,
	parameter int RADIUS_WIDTH = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mer_pkg::mer_cmd_t              cmd,
	output mer_pkg::mer_stat_t             stat,
	input  logic [COORD_WIDTH-1:0]        center_x,
	input  logic [COORD_WIDTH-1:0]        center_y,
	input  logic [RADIUS_WIDTH-1:0]       radius_x,
	input  logic [RADIUS_WIDTH-1:0]       radius_y,
	input  logic [23:0]                   color,
	output logic signed [COORD_WIDTH+1:0] right_x,
	output logic signed [COORD_WIDTH+1:0] left_x,
	output logic signed [COORD_WIDTH+1:0] lower_y,
	output logic signed [COORD_WIDTH+1:0] upper_y,
	output logic [23:0]                   pixel_color,
	output logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready
);
	import mer_pkg::*;

	localparam int R     = RADIUS_WIDTH;
	localparam int W     = COORD_WIDTH;
	localparam int OW    = 2 * R + 5;
	localparam int DW    = 4 * R + 8;
	localparam int SQW   = 2 * R;
	localparam int OUT_W = W + 2;
	localparam int SW    = ((W > R + 1) ? W : R + 1) + 2;

	logic [R:0]             x_q;
	logic [R-1:0]           y_q;
	logic [R-1:0]           rx_q, ry_q;
	logic [W-1:0]           cx_q, cy_q;
	logic [23:0]            color_q;
	logic [SQW-1:0]         rxsq_q, rysq_q;
	logic signed [DW-1:0]   gx_q, gy_q, d_q, prod_q, acc_q;
	logic                   r2_q, busy_q, moved_q, out_valid_q;
	logic signed [OUT_W-1:0] right_q, left_q, lower_q, upper_q;
	logic [23:0]            out_color_q;
	logic                   out_last_q;

	logic signed [DW-1:0]   rxsq_x, rysq_x, dec_term;
	logic signed [R+2:0]    tx;
	logic signed [R:0]      ty;
	logic signed [OW-1:0]   mul_a, mul_b;
	logic signed [2*OW-1:0] mul_p;
	logic                   moved_now, step_x, step_y, fin;
	logic signed [SW-1:0]   cx_e, cy_e, x_e, y_e;
	logic signed [SW-1:0]   right_full, left_full, lower_full, upper_full;

	assign rxsq_x = $signed(DW'(rxsq_q));
	assign rysq_x = $signed(DW'(rysq_q));
	assign tx     = $signed({1'b0, x_q, 1'b1});
	assign ty     = $signed({1'b0, y_q} - (R + 1)'(1));

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_RX_RX: begin
				mul_a = OW'($signed({1'b0, rx_q}));
				mul_b = OW'($signed({1'b0, rx_q}));
			end
			MUL_RY_RY: begin
				mul_a = OW'($signed({1'b0, ry_q}));
				mul_b = OW'($signed({1'b0, ry_q}));
			end
			MUL_RXSQ_RY: begin
				mul_a = OW'($signed({1'b0, rxsq_q}));
				mul_b = OW'($signed({1'b0, ry_q}));
			end
			MUL_TX_TX: begin
				mul_a = OW'(tx);
				mul_b = OW'(tx);
			end
			MUL_RYSQ_PROD: begin
				mul_a = OW'($signed({1'b0, rysq_q}));
				mul_b = $signed(prod_q[OW-1:0]);
			end
			MUL_TY_TY: begin
				mul_a = OW'(ty);
				mul_b = OW'(ty);
			end
			MUL_RXSQ_PROD: begin
				mul_a = OW'($signed({1'b0, rxsq_q}));
				mul_b = $signed(prod_q[OW-1:0]);
			end
			MUL_RXSQ_RYSQ: begin
				mul_a = OW'($signed({1'b0, rxsq_q}));
				mul_b = OW'($signed({1'b0, rysq_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Region one moves y when the decision is not negative; region two moves x
	// when it is not positive.
	assign moved_now = r2_q ? (d_q[DW-1] || (d_q == '0)) : !d_q[DW-1];
	assign step_x    = !r2_q || moved_now;
	assign step_y    = r2_q || moved_now;

	assign dec_term = ((!r2_q || moved_q) ? gx_q : DW'(0))
	                - ((r2_q || moved_q) ? gy_q : DW'(0))
	                + (r2_q ? rxsq_x : rysq_x);

	assign fin = r2_q && (y_q == '0);

	assign cx_e       = $signed(SW'(cx_q));
	assign cy_e       = $signed(SW'(cy_q));
	assign x_e        = $signed(SW'(x_q));
	assign y_e        = $signed(SW'(y_q));
	assign right_full = cx_e + x_e;
	assign left_full  = cx_e - x_e;
	assign lower_full = cy_e + y_e;
	assign upper_full = cy_e - y_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_q        <= 1'b0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				r2_q <= 1'b0;
			end else if (cmd.r2_finish) begin
				r2_q <= 1'b1;
			end
			if (cmd.emit) begin
				busy_q      <= !fin;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			rx_q    <= radius_x;
			ry_q    <= radius_y;
			color_q <= color;
			x_q     <= '0;
			y_q     <= radius_y;
		end
		if (cmd.mul_en) begin
			prod_q <= $signed(mul_p[DW-1:0]);
		end
		if (cmd.save_rxsq) begin
			rxsq_q <= prod_q[SQW-1:0];
		end
		if (cmd.save_rysq) begin
			rysq_q <= prod_q[SQW-1:0];
		end
		if (cmd.init) begin
			gx_q <= '0;
			gy_q <= prod_q <<< 1;
			d_q  <= (rysq_x <<< 2) + rxsq_x - (prod_q <<< 2);
		end
		if (cmd.adv_pos) begin
			moved_q <= moved_now;
			if (step_x) begin
				x_q  <= x_q + (R + 1)'(1);
				gx_q <= gx_q + (rysq_x <<< 1);
			end
			if (step_y) begin
				y_q  <= y_q - R'(1);
				gy_q <= gy_q - (rxsq_x <<< 1);
			end
		end
		if (cmd.adv_dec) begin
			d_q <= d_q + (dec_term <<< 2);
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q;
		end
		if (cmd.acc_add) begin
			acc_q <= acc_q + (prod_q <<< 2);
		end
		if (cmd.r2_finish) begin
			d_q <= acc_q - (prod_q <<< 2);
		end
		if (cmd.emit) begin
			right_q     <= right_full[OUT_W-1:0];
			left_q      <= left_full[OUT_W-1:0];
			lower_q     <= lower_full[OUT_W-1:0];
			upper_q     <= upper_full[OUT_W-1:0];
			out_color_q <= color_q;
			out_last_q  <= fin;
		end
	end

	assign stat.busy       = busy_q;
	assign stat.region_two = r2_q;
	assign stat.grad_lt    = (gx_q < gy_q);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign right_x     = right_q;
	assign left_x      = left_q;
	assign lower_y     = lower_q;
	assign upper_y     = upper_q;
	assign pixel_color = out_color_q;
	assign last        = out_last_q;
	assign out_valid   = out_valid_q;

endmodule

// ----- design/midpoint_ellipse_rasterizer.sv -----
// Top level of the midpoint ellipse rasterizer: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Usage. Items enter on the s_ stream: s_tuser is the operation (start or step) and
// s_tdata carries center, radii and color, which are read on a start only. A start
// transfer loads a new ellipse and produces its first point (0, radius_y) of the first
// quadrant; each step transfer produces the next point. A step sent while no ellipse
// is running is taken and dropped without a result. Each result leaves on the m_
// stream with the four mirrored coordinates and the color in m_tdata; m_tlast marks
// the final point of the ellipse, after which steps are dropped again.
// Flow. The controller takes one item at a time, so s_tready is high only while it
// waits. A step runs through the position step, decision update, check and output
// states before its result is valid. A start first sends rx*rx, ry*ry and rx*rx*ry
// through the one shared multiplier in turn. The point at which the ellipse enters its
// second region also runs the five products of the new decision value through it.
// Reset clears the controller to idle and drops any running ellipse and any result
// waiting in the output register. The output register lets the block take the next
// item while a result waits; when the receiver holds m_tready low, the block finishes
// that next item and then waits in its output state until the register frees up.

module midpoint_ellipse_rasterizer #(
	parameter int COORD_WIDTH  = 11,
	parameter int RADIUS_WIDTH = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// center_x, center_y, radius_x, radius_y, color; zero padded
	input  logic [((2 * COORD_WIDTH + 2 * RADIUS_WIDTH + 24 + 7) / 8) * 8 - 1:0] s_tdata,
	// op
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// right_x, left_x, lower_y, upper_y, pixel_color; zero padded
	output logic [((4 * (COORD_WIDTH + 2) + 24 + 7) / 8) * 8 - 1:0] m_tdata,
	output logic m_tlast
);
	import mer_pkg::*;

	localparam int W      = COORD_WIDTH;
	localparam int R      = RADIUS_WIDTH;
	localparam int OUT_W  = W + 2;
	localparam int OUT_DW = ((4 * OUT_W + 24 + 7) / 8) * 8;
	localparam int CY_LO  = W;
	localparam int RX_LO  = 2 * W;
	localparam int RY_LO  = 2 * W + R;
	localparam int COL_LO = 2 * W + 2 * R;

	mer_cmd_t  cmd;
	mer_stat_t stat;

	logic signed [OUT_W-1:0] right_x, left_x, lower_y, upper_y;
	logic [23:0]             pixel_color;

	mer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Input fields are sliced straight from the transfer; the datapath samples them
	// only in the cycle the start is taken.
	mer_dp #(
		.COORD_WIDTH  (COORD_WIDTH),
		.RADIUS_WIDTH (RADIUS_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.center_x    (s_tdata[W-1:0]),
		.center_y    (s_tdata[CY_LO+W-1:CY_LO]),
		.radius_x    (s_tdata[RX_LO+R-1:RX_LO]),
		.radius_y    (s_tdata[RY_LO+R-1:RY_LO]),
		.color       (s_tdata[COL_LO+23:COL_LO]),
		.right_x     (right_x),
		.left_x      (left_x),
		.lower_y     (lower_y),
		.upper_y     (upper_y),
		.pixel_color (pixel_color),
		.last        (m_tlast),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready)
	);

	// The size cast fills the unused top bits with zeros.
	assign m_tdata = OUT_DW'({pixel_color, upper_y, lower_y, left_x, right_x});

	// A result is only written into the output register when it is empty or being taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("result written over a pending transfer");

	// While the final point waits, no ellipse is marked as running.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> !stat.busy)
		else $error("ellipse still running after its last point");

	// A step taken while idle is dropped and the block is ready again next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == OP_STEP) && !stat.busy) |=> s_tready)
		else $error("idle step was not dropped");

	// The second region is entered only once per ellipse.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.r2_finish |-> !stat.region_two)
		else $error("second region entered twice");

endmodule
